/* design/assert_macros.svh */
// Assertion helpers shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define SEM_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Condition that must hold in the cycle after the trigger.
`define SEM_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

/* design/sem_pkg.sv */
package sem_pkg;

    localparam int PIX_W        = 24;
    localparam int CFG_DW       = 13;
    localparam int CFG_IW       = 1;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int SAT_SUM      = 65280;
    localparam int JOB_DEPTH    = 4;
    localparam int JOB_AW       = 2;
    localparam int OUT_DEPTH    = 16;
    localparam int OUT_AW       = 4;

    localparam logic [CFG_IW-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IW-1:0] REG_FRAME_HEIGHT = 1'b1;

    typedef logic [PIX_W-1:0] pixel_t;

    // Window rows r-2, r-1, r by columns c-2, c-1, c; emit bits in result order:
    // centre (r-1,c-1), right edge (r-1,c), bottom edge (r,c-1), corner (r,c).
    typedef struct packed {
        pixel_t [2:0][2:0] win;
        logic   [3:0]      emit;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } jq_stat_t;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       run_last;
    } result_t;

endpackage

/* design/sobel_edge_magnitude_rgb_core.sv */
// Streaming 3x3 Sobel edge magnitude on RGB pixels in raster order, with
// zero padding outside the frame. A pixel is taken every clock while the front
// stage can hand its window to the job queue; each pixel yields zero to four
// results (more at the right and bottom edges), and the back end issues one
// result per clock, while result-queue credit remains, into a 16-deep result
// queue, so a sustained rate of one pixel per clock holds until end-of-row
// bursts fill the job queue. A result passes the front stage, the job queue,
// gradient, sum of squares, eight root-bit stages, and rounding into the result
// queue. The line stores are MAX_WIDTH deep, need no clearing pass and hold
// across frames; a register write restarts the frame at row 0, column 0.
module sobel_edge_magnitude_rgb_core
    import sem_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [7:0]        in_blue,
    input  logic [7:0]        in_green,
    input  logic [7:0]        in_red,
    input  logic              cfg_we,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_data,
    output logic              empty,
    input  logic              pop,
    output logic [7:0]        edge_blue,
    output logic [7:0]        edge_green,
    output logic [7:0]        edge_red,
    output logic              run_last
);

    jq_stat_t jq_stat;
    job_t     fe_job;
    job_t     head_job;
    logic     fe_push;
    logic     be_pop;
    result_t  res;

    sem_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .pix       ({in_red, in_green, in_blue}),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .jq_stat   (jq_stat),
        .job_push  (fe_push),
        .job       (fe_job)
    );

    sem_job_fifo u_jobs (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (fe_push),
        .wr_job (fe_job),
        .rd     (be_pop),
        .head   (head_job),
        .stat   (jq_stat)
    );

    sem_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .job     (head_job),
        .jq_stat (jq_stat),
        .job_pop (be_pop),
        .empty   (empty),
        .pop     (pop),
        .res     (res)
    );

    assign edge_blue  = res.blue;
    assign edge_green = res.green;
    assign edge_red   = res.red;
    assign run_last   = res.run_last;

endmodule

/* design/sem_front.sv */
module sem_front
    import sem_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  pixel_t            pix,
    input  logic              cfg_we,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_data,
    input  jq_stat_t          jq_stat,
    output logic              job_push,
    output job_t              job
);

`include "assert_macros.svh"

    localparam int AW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW   = AW + 1;
    localparam int CMPW = AW + 12;

    logic [10:0]   frame_width_reg;
    logic [12:0]   frame_height_reg;
    logic [AW-1:0] col_reg;
    logic [11:0]   row_reg;
    logic [WW-1:0] w_eff;
    logic [12:0]   h_eff;
    logic          last_col;
    logic          last_row;
    logic          accept;
    logic          advance;

    logic          a_valid_reg;
    pixel_t        a_pix_reg;
    logic [AW-1:0] a_col_reg;
    logic          a_czero_reg;
    logic          a_up1_reg;
    logic          a_up2_reg;
    logic [3:0]    a_emit_reg;
    pixel_t        rd1_reg;
    pixel_t        rd2_reg;
    logic          byp_reg;
    pixel_t        byp1_reg;
    pixel_t        byp2_reg;
    pixel_t        raw1;
    pixel_t        raw2;

    pixel_t        line_above_mem [MAX_WIDTH];
    pixel_t        line_two_mem [MAX_WIDTH];

    pixel_t [2:0][2:0] win_reg;
    pixel_t [2:0][2:0] win_next;

    always_comb
    begin
        if (frame_width_reg == '0)
            w_eff = WW'(1);
        else if (CMPW'(frame_width_reg) > CMPW'(MAX_WIDTH))
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(frame_width_reg);

        if (frame_height_reg == '0)
            h_eff = 13'd1;
        else if (frame_height_reg > 13'(HEIGHT_LIMIT))
            h_eff = 13'(HEIGHT_LIMIT);
        else
            h_eff = frame_height_reg;
    end

    assign last_col = (WW'(col_reg) + WW'(1)) == w_eff;
    assign last_row = (13'(row_reg) + 13'd1) == h_eff;

    assign advance = a_valid_reg && !jq_stat.full;
    assign full    = a_valid_reg && !advance;
    assign accept  = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= 11'd1024;
            frame_height_reg <= 13'd1024;
            col_reg          <= '0;
            row_reg          <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[10:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default:          frame_height_reg <= frame_height_reg;
            endcase
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            if (last_col)
            begin
                col_reg <= '0;
                row_reg <= last_row ? '0 : row_reg + 12'd1;
            end
            else
            begin
                col_reg <= col_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            byp_reg     <= 1'b0;
        end
        else if (accept)
        begin
            a_valid_reg <= 1'b1;
            // the store write of the item ahead lands at this same edge
            byp_reg     <= advance && (a_col_reg == col_reg);
        end
        else if (advance)
        begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_pix_reg   <= pix;
            a_col_reg   <= col_reg;
            a_czero_reg <= (col_reg == '0);
            a_up1_reg   <= (row_reg != '0);
            a_up2_reg   <= (row_reg > 12'd1);
            a_emit_reg  <= {last_row && last_col, last_row && (col_reg != '0),
                            (row_reg != '0) && last_col,
                            (row_reg != '0) && (col_reg != '0)};
            byp1_reg    <= a_pix_reg;
            byp2_reg    <= raw1;
        end
    end

    assign raw1 = byp_reg ? byp1_reg : rd1_reg;
    assign raw2 = byp_reg ? byp2_reg : rd2_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            line_above_mem[a_col_reg] <= a_pix_reg;
            line_two_mem[a_col_reg]   <= raw1;
        end
        if (accept)
        begin
            rd1_reg <= line_above_mem[col_reg];
            rd2_reg <= line_two_mem[col_reg];
        end
    end

    always_comb
    begin
        win_next = a_czero_reg ? '0 : win_reg;
        for (int k = 0; k < 3; k++)
        begin
            win_next[k][0] = win_next[k][1];
            win_next[k][1] = win_next[k][2];
        end
        win_next[0][2] = a_up2_reg ? raw2 : '0;
        win_next[1][2] = a_up1_reg ? raw1 : '0;
        win_next[2][2] = a_pix_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            win_reg <= '0;
        else if (advance)
            win_reg <= win_next;
    end

    assign job_push = advance && (a_emit_reg != '0);
    assign job.win  = win_next;
    assign job.emit = a_emit_reg;

    `SEM_ASSERT(col_in_frame, WW'(col_reg) < w_eff, "column position beyond frame width")
    `SEM_ASSERT(row_in_frame, 13'(row_reg) < h_eff, "row position beyond frame height")
    `SEM_ASSERT_NEXT(stage_hold, a_valid_reg && !advance,
                     a_valid_reg && $stable(a_col_reg), "stalled pixel lost its slot")

endmodule

/* design/sem_job_fifo.sv */
module sem_job_fifo
    import sem_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr,
    input  job_t     wr_job,
    input  logic     rd,
    output job_t     head,
    output jq_stat_t stat
);

    job_t              slot_reg [JOB_DEPTH];
    logic [JOB_AW-1:0] wr_ptr_reg;
    logic [JOB_AW-1:0] rd_ptr_reg;
    logic [JOB_AW:0]   cnt_reg;
    logic              do_wr;
    logic              do_rd;

    assign stat.full  = (cnt_reg == (JOB_AW+1)'(JOB_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign do_wr      = wr && !stat.full;
    assign do_rd      = rd && !stat.empty;
    assign head       = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + JOB_AW'(1);
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + JOB_AW'(1);
            cnt_reg <= cnt_reg + (JOB_AW+1)'(do_wr) - (JOB_AW+1)'(do_rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_job;
    end

endmodule

/* design/sem_back.sv */
module sem_back
    import sem_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  job_t     job,
    input  jq_stat_t jq_stat,
    output logic     job_pop,
    output logic     empty,
    input  logic     pop,
    output result_t  res
);

`include "assert_macros.svh"

    localparam int NST = 9;

    logic [3:0]        done_reg;
    logic [3:0]        remaining;
    logic [3:0]        pick;
    logic              is_last;
    logic              issue;
    logic              dr;
    logic              dc;
    pixel_t [2:0][2:0] sub;

    logic              g_valid_reg;
    logic              g_last_reg;
    logic signed [10:0] gx_reg [3];
    logic signed [10:0] gy_reg [3];
    logic signed [10:0] gx [3];
    logic signed [10:0] gy [3];

    logic              st_valid_reg [NST];
    logic              st_last_reg [NST];
    logic [15:0]       st_s_reg [NST][3];
    logic [7:0]        st_q_reg [NST][3];
    logic              st_sat_reg [NST][3];
    logic [7:0]        step_q [NST][3];

    logic [7:0]        mag [3];
    result_t           fin;

    result_t           out_mem [OUT_DEPTH];
    logic [OUT_AW-1:0] wr_ptr_reg;
    logic [OUT_AW-1:0] rd_ptr_reg;
    logic [OUT_AW:0]   out_cnt_reg;
    logic [OUT_AW:0]   reserved_reg;
    logic              rd;
    logic              wr;

    // pick the next pending result of the head job
    assign remaining = job.emit & ~done_reg;
    assign pick      = remaining & (~remaining + 4'd1);
    assign is_last   = (remaining & ~pick) == '0;
    assign issue     = !jq_stat.empty && (reserved_reg < (OUT_AW+1)'(OUT_DEPTH));
    assign job_pop   = issue && is_last;
    assign dr        = pick[2] || pick[3];
    assign dc        = pick[1] || pick[3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= '0;
        else if (issue)
            done_reg <= is_last ? '0 : (done_reg | pick);
    end

    always_comb
    begin
        int kk;
        int ll;
        for (int k = 0; k < 3; k++)
        begin
            for (int l = 0; l < 3; l++)
            begin
                kk = k + int'(dr);
                ll = l + int'(dc);
                if (kk < 3 && ll < 3)
                    sub[k][l] = job.win[kk[1:0]][ll[1:0]];
                else
                    sub[k][l] = '0;
            end
        end
    end

    always_comb
    begin
        logic signed [10:0] v [3][3];
        for (int ch = 0; ch < 3; ch++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                for (int l = 0; l < 3; l++)
                    v[k][l] = $signed({3'b000, sub[k][l][8*ch +: 8]});
            end
            gx[ch] = v[0][2] - v[0][0] + ((v[1][2] - v[1][0]) <<< 1) + v[2][2] - v[2][0];
            gy[ch] = v[2][0] - v[0][0] + ((v[2][1] - v[0][1]) <<< 1) + v[2][2] - v[0][2];
        end
    end

    // one root bit per stage, most significant first
    always_comb
    begin
        logic [7:0]  t;
        logic [15:0] tt;
        for (int ch = 0; ch < 3; ch++)
        begin
            step_q[0][ch] = st_q_reg[0][ch];
            for (int j = 1; j < NST; j++)
            begin
                t  = st_q_reg[j-1][ch] | (8'h80 >> (j - 1));
                tt = 16'(t) * 16'(t);
                step_q[j][ch] = (tt <= st_s_reg[j-1][ch]) ? t : st_q_reg[j-1][ch];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_valid_reg <= 1'b0;
            for (int j = 0; j < NST; j++)
                st_valid_reg[j] <= 1'b0;
        end
        else
        begin
            g_valid_reg     <= issue;
            st_valid_reg[0] <= g_valid_reg;
            for (int j = 1; j < NST; j++)
                st_valid_reg[j] <= st_valid_reg[j-1];
        end
    end

    always_ff @(posedge clk)
    begin
        logic [21:0] ss;
        g_last_reg     <= is_last;
        st_last_reg[0] <= g_last_reg;
        for (int ch = 0; ch < 3; ch++)
        begin
            gx_reg[ch] <= gx[ch];
            gy_reg[ch] <= gy[ch];
            ss = 22'(gx_reg[ch] * gx_reg[ch]) + 22'(gy_reg[ch] * gy_reg[ch]);
            st_s_reg[0][ch]   <= ss[15:0];
            st_sat_reg[0][ch] <= ss >= 22'(SAT_SUM);
            st_q_reg[0][ch]   <= '0;
        end
        for (int j = 1; j < NST; j++)
        begin
            st_last_reg[j] <= st_last_reg[j-1];
            for (int ch = 0; ch < 3; ch++)
            begin
                st_s_reg[j][ch]   <= st_s_reg[j-1][ch];
                st_sat_reg[j][ch] <= st_sat_reg[j-1][ch];
                st_q_reg[j][ch]   <= step_q[j][ch];
            end
        end
    end

    // round to nearest, saturating at 8'hFF: step up when s lies above q*q + q
    always_comb
    begin
        logic [16:0] qq;
        logic [7:0]  q;
        for (int ch = 0; ch < 3; ch++)
        begin
            q  = st_q_reg[NST-1][ch];
            qq = 17'(q) * 17'(q) + 17'(q);
            if (st_sat_reg[NST-1][ch])
                mag[ch] = 8'hFF;
            else if (17'(st_s_reg[NST-1][ch]) > qq)
                mag[ch] = q + 8'd1;
            else
                mag[ch] = q;
        end
    end

    assign fin.blue     = mag[0];
    assign fin.green    = mag[1];
    assign fin.red      = mag[2];
    assign fin.run_last = st_last_reg[NST-1];

    assign wr    = st_valid_reg[NST-1];
    assign empty = (out_cnt_reg == '0);
    assign rd    = pop && !empty;
    assign res   = out_mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            out_cnt_reg  <= '0;
            reserved_reg <= '0;
        end
        else
        begin
            if (wr)
                wr_ptr_reg <= wr_ptr_reg + OUT_AW'(1);
            if (rd)
                rd_ptr_reg <= rd_ptr_reg + OUT_AW'(1);
            out_cnt_reg  <= out_cnt_reg + (OUT_AW+1)'(wr) - (OUT_AW+1)'(rd);
            // slots held by results in the pipe as well as in the queue
            reserved_reg <= reserved_reg + (OUT_AW+1)'(issue) - (OUT_AW+1)'(rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            out_mem[wr_ptr_reg] <= fin;
    end

    `SEM_ASSERT(credit_bound, reserved_reg <= (OUT_AW+1)'(OUT_DEPTH),
                "result credit overrun")
    `SEM_ASSERT(queue_in_credit, out_cnt_reg <= reserved_reg,
                "result queue holds more than reserved")

endmodule
